>>> sv/scc_pkg.sv
// Shared types and constants for the sector cache clock controller.
package scc_pkg;

  // Field widths of the request and result channels.
  localparam int TYPE_W   = 2;
  localparam int SECTOR_W = 32;
  localparam int SLOT_W   = 6;

  // Request type codes.
  localparam logic [TYPE_W-1:0] REQ_READ  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_FLUSH = 2'd2;

  // Which kind of result the datapath should build and commit.
  typedef enum logic [2:0] {
    EMIT_NONE  = 3'd0,
    EMIT_HIT   = 3'd1,
    EMIT_MISS  = 3'd2,
    EMIT_FLUSH = 3'd3,
    EMIT_IDLE  = 3'd4
  } emit_e_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;        // capture the request and rewind the scan index
    logic    scan_step;   // read the next tag for lookup and advance the index
    logic    sweep_step;  // clear the reference bit under the hand and advance it
    logic    rd_victim;   // read the tag under the hand and latch its dirty state
    logic    rd_flush;    // read the tag at the scan index for a flush
    logic    idx_inc;     // advance the scan index during a flush
    emit_e_t emit;        // result to produce this cycle
  } scc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_access;    // registered request is a read or a write
    logic is_flush;     // registered request is a flush
    logic hit_found;    // compare stage matched a valid slot
    logic miss_found;   // compare stage passed the last slot without a match
    logic sweep_stop;   // slot under the hand can be taken
    logic idx_dirty;    // slot at the scan index is dirty
    logic flush_last;   // slot at the scan index is the last dirty one
    logic dirty_none;   // no slot is dirty
    logic out_free;     // result register can take a new result
  } scc_stat_t;

endpackage

>>> sv/scc_ctrl.sv
// Control state machine that sequences lookup, clock sweep and flush.
module scc_ctrl
  import scc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  scc_stat_t st,
  output scc_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_DISPATCH  = 11'b00000000010,
    S_LOOKUP    = 11'b00000000100,
    S_HIT_OUT   = 11'b00000001000,
    S_SWEEP     = 11'b00000010000,
    S_VREAD     = 11'b00000100000,
    S_MISS_OUT  = 11'b00001000000,
    S_FSCAN     = 11'b00010000000,
    S_FREAD     = 11'b00100000000,
    S_FLUSH_OUT = 11'b01000000000,
    S_IDLE_OUT  = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A new request is taken only while no request is in progress.
  assign req_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.is_access) begin
          state_next = S_LOOKUP;
        end else if (st.is_flush && !st.dirty_none) begin
          state_next = S_FSCAN;
        end else begin
          state_next = S_IDLE_OUT;
        end
      end
      S_LOOKUP: begin
        if (st.hit_found) begin
          state_next = S_HIT_OUT;
        end else if (st.miss_found) begin
          state_next = S_SWEEP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_HIT_OUT: begin
        if (st.out_free) begin
          cmd.emit   = EMIT_HIT;
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (st.sweep_stop) begin
          state_next = S_VREAD;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      S_VREAD: begin
        cmd.rd_victim = 1'b1;
        state_next    = S_MISS_OUT;
      end
      S_MISS_OUT: begin
        if (st.out_free) begin
          cmd.emit   = EMIT_MISS;
          state_next = S_IDLE;
        end
      end
      S_FSCAN: begin
        if (st.idx_dirty) begin
          state_next = S_FREAD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_FREAD: begin
        cmd.rd_flush = 1'b1;
        state_next   = S_FLUSH_OUT;
      end
      S_FLUSH_OUT: begin
        if (st.out_free) begin
          cmd.emit = EMIT_FLUSH;
          if (st.flush_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_FSCAN;
          end
        end
      end
      S_IDLE_OUT: begin
        if (st.out_free) begin
          cmd.emit   = EMIT_IDLE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/scc_dp.sv
// Datapath: slot flags, tag memory, clock hand, scan index and result register.
module scc_dp
  import scc_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [TYPE_W-1:0]   req_type,
  input  logic [SECTOR_W-1:0] sector,
  input  scc_cmd_t            cmd,
  output scc_stat_t           st,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                hit,
  output logic [SLOT_W-1:0]   slot,
  output logic                fill_needed,
  output logic                writeback_needed,
  output logic [SECTOR_W-1:0] writeback_sector,
  output logic                last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // Request registers.
  logic [TYPE_W-1:0]   type_q;
  logic [SECTOR_W-1:0] sector_q;

  // Per-slot flags, cleared by reset.
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] dirty;
  logic [SLOTS-1:0] refd;

  // Tag memory with registered read data.
  logic [SECTOR_W-1:0] tag_mem [SLOTS];
  logic [SECTOR_W-1:0] tag_q;
  logic [IW-1:0]       rd_addr;
  logic                rd_en;
  logic                wr_en;

  // Scan index, clock hand and lookup compare stage.
  logic [IW-1:0] idx;
  logic [IW-1:0] hand;
  logic [IW-1:0] hand_next;
  logic [IW-1:0] lk_idx;
  logic          lk_pend;
  logic          lk_vld;
  logic          wb_q;
  logic          is_write;
  logic [SLOTS-1:0] dirty_rest;

  assign is_write  = (type_q == REQ_WRITE);
  assign hand_next = (hand == LAST_IDX) ? '0 : hand + 1'b1;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_q   <= req_type;
      sector_q <= sector;
    end
  end

  // Tag memory port: one read and one write per cycle.
  assign rd_en   = cmd.scan_step | cmd.rd_victim | cmd.rd_flush;
  assign rd_addr = cmd.rd_victim ? hand : idx;
  assign wr_en   = (cmd.emit == EMIT_MISS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[hand] <= sector_q;
    end
    if (rd_en) begin
      tag_q <= tag_mem[rd_addr];
    end
  end

  // Scan index, compare stage and victim dirty latch.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      lk_pend <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx     <= '0;
        lk_pend <= 1'b0;
      end else if (cmd.scan_step) begin
        idx     <= idx + 1'b1;
        lk_pend <= 1'b1;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      lk_idx <= idx;
      lk_vld <= valid[idx];
    end
    if (cmd.rd_victim) begin
      wb_q <= valid[hand] & dirty[hand];
    end
  end

  // Clock hand and slot flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      hand  <= '0;
      valid <= '0;
      dirty <= '0;
      refd  <= '0;
    end else begin
      if (cmd.sweep_step) begin
        refd[hand] <= 1'b0;
        hand       <= hand_next;
      end
      case (cmd.emit)
        EMIT_HIT: begin
          refd[lk_idx] <= 1'b1;
          if (is_write) begin
            dirty[lk_idx] <= 1'b1;
          end
        end
        EMIT_MISS: begin
          valid[hand] <= 1'b1;
          dirty[hand] <= is_write;
          refd[hand]  <= 1'b1;
        end
        EMIT_FLUSH: begin
          dirty[idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Dirty slots other than the one at the scan index.
  always_comb begin
    dirty_rest      = dirty;
    dirty_rest[idx] = 1'b0;
  end

  // Status to the controller.
  always_comb begin
    st            = '0;
    st.is_access  = (type_q == REQ_READ) || (type_q == REQ_WRITE);
    st.is_flush   = (type_q == REQ_FLUSH);
    st.hit_found  = lk_pend && lk_vld && (tag_q == sector_q);
    st.miss_found = lk_pend && !(lk_vld && (tag_q == sector_q)) && (lk_idx == LAST_IDX);
    st.sweep_stop = !valid[hand] || !refd[hand];
    st.idx_dirty  = dirty[idx];
    st.flush_last = (dirty_rest == '0);
    st.dirty_none = (dirty == '0);
    st.out_free   = !res_valid || !res_stall;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      EMIT_HIT: begin
        hit              <= 1'b1;
        slot             <= SLOT_W'(lk_idx);
        fill_needed      <= 1'b0;
        writeback_needed <= 1'b0;
        writeback_sector <= '0;
        last             <= 1'b1;
      end
      EMIT_MISS: begin
        hit              <= 1'b0;
        slot             <= SLOT_W'(hand);
        fill_needed      <= 1'b1;
        writeback_needed <= wb_q;
        writeback_sector <= wb_q ? tag_q : '0;
        last             <= 1'b1;
      end
      EMIT_FLUSH: begin
        hit              <= 1'b0;
        slot             <= SLOT_W'(idx);
        fill_needed      <= 1'b0;
        writeback_needed <= 1'b1;
        writeback_sector <= tag_q;
        last             <= st.flush_last;
      end
      EMIT_IDLE: begin
        hit              <= 1'b0;
        slot             <= '0;
        fill_needed      <= 1'b0;
        writeback_needed <= 1'b0;
        writeback_sector <= '0;
        last             <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/sector_cache_clock_controller_unit.sv
// Top level of the sector cache clock controller: controller plus datapath.
//
//   Channel   Handshake              Fields
//   request   req_valid / req_stall  req_type, sector
//   result    res_valid / res_stall  hit, slot, fill_needed, writeback_needed,
//                                    writeback_sector, last
//
// One request is handled at a time; req_stall stays high until its last result
// is posted. The tag memory has one read port, so the lookup compares one slot
// per cycle; a hit ends the scan at the matching slot and posts its result.
// A miss compares all SLOTS tags, then the hand clears the reference bit of each
// referenced slot it passes and stops at the first slot that is invalid or
// unreferenced; that slot is the victim and the miss result follows.
// A flush scans the slots up to the last dirty one and posts one result per
// dirty slot; a request with no work posts a single idle result.
// Reset clears the slot flags and the hand at once; the tag memory is not cleared.
// A stalled result holds the next result back; the request side waits meanwhile.
module sector_cache_clock_controller_unit
  import scc_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [TYPE_W-1:0]   req_type,
  input  logic [SECTOR_W-1:0] sector,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                hit,
  output logic [SLOT_W-1:0]   slot,
  output logic                fill_needed,
  output logic                writeback_needed,
  output logic [SECTOR_W-1:0] writeback_sector,
  output logic                last
);

  scc_cmd_t  cmd;
  scc_stat_t st;

  // Sequencer for lookup, sweep and flush.
  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // Slot state, tags and result register.
  scc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .req_type         (req_type),
    .sector           (sector),
    .cmd              (cmd),
    .st               (st),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .hit              (hit),
    .slot             (slot),
    .fill_needed      (fill_needed),
    .writeback_needed (writeback_needed),
    .writeback_sector (writeback_sector),
    .last             (last)
  );

endmodule
